[rtl/factor_shape_accumulator_core_assert.svh]
// Assertion macros shared by the checker of the factor shape accumulator.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef FACTOR_SHAPE_ACCUMULATOR_CORE_ASSERT_SVH
`define FACTOR_SHAPE_ACCUMULATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/fsa_pkg.sv]
// Shared types and constants of the factor shape accumulator.
// Used by the product unit, the top level and the port checker; depends on nothing.
`default_nettype none

package fsa_pkg;

   // Fixed-point widths: sums are Q48.16, probabilities carry 15 fraction bits.
   localparam int SUM_W     = 64;
   localparam int PRIOR_W   = 32;
   localparam int PROB_FRAC = 15;
   localparam int XA_W      = 33;
   localparam int XAB_W     = 34;

   // Operation codes of an input word.
   localparam logic OP_ACCUMULATE = 1'b0;
   localparam logic OP_READ       = 1'b1;

   // Store selectors of a read word.
   localparam logic [1:0] SEL_ROW_FACTOR    = 2'd0;
   localparam logic [1:0] SEL_COLUMN_FACTOR = 2'd1;
   localparam logic [1:0] SEL_FACTOR_TOTAL  = 2'd2;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_ROW_PRIOR    = 2'd0;
   localparam logic [1:0] CSR_COLUMN_PRIOR = 2'd1;
   localparam logic [1:0] CSR_FACTOR_PRIOR = 2'd2;

   // Every prior resets to 1.0 in Q16.16.
   localparam logic [PRIOR_W-1:0] PRIOR_RESET = 32'h0001_0000;

   typedef struct packed {
      logic        op;
      logic [9:0]  row_index;
      logic [3:0]  factor_index;
      logic [7:0]  col_index;
      logic [31:0] count_value;
      logic [15:0] phi_a_value;
      logic [15:0] phi_b_value;
      logic [1:0]  which_store;
      logic [13:0] read_index;
   } req_word_type;

   typedef struct packed {
      logic [63:0] read_value;
      logic        is_read;
   } rsp_word_type;

   // Load strobes from the sequencer to the product unit.
   typedef struct packed {
      logic load_xa;
      logic load_xab;
   } mul_ctl_type;

endpackage

`default_nettype wire

[rtl/fsa_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; every store of the accumulator is one instance of it.
`default_nettype none

module fsa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/fsa_product.sv]
// Two-step fixed-point product unit: x*pa and then (x*pa)*pb, each truncated.
// Depends on fsa_pkg for widths and the load strobe structure.
`default_nettype none

module fsa_product import fsa_pkg::*; (
   input  wire logic              clock,
   input  wire mul_ctl_type       ctl,
   input  wire logic [31:0]       count_value,
   input  wire logic [15:0]       phi_a_value,
   input  wire logic [15:0]       phi_b_value,
   output logic      [XA_W-1:0]   xa,
   output logic      [XAB_W-1:0]  xab
);

   logic [47:0]      prod_a;
   logic [48:0]      prod_b;
   logic [XA_W-1:0]  xa_ff;
   logic [XA_W-1:0]  xa_in;
   logic [XAB_W-1:0] xab_ff;
   logic [XAB_W-1:0] xab_in;

   // First product, scaled back to Q16.16 by dropping the probability fraction.
   always_comb begin
      prod_a = 48'(count_value) * 48'(phi_a_value);
      xa_in  = prod_a[47:PROB_FRAC];
   end

   // Second product uses the registered first one.
   always_comb begin
      prod_b = 49'(xa_ff) * 49'(phi_b_value);
      xab_in = prod_b[48:PROB_FRAC];
   end

   always_ff @(posedge clock) begin
      if (ctl.load_xa) begin
         xa_ff <= xa_in;
      end
      if (ctl.load_xab) begin
         xab_ff <= xab_in;
      end
   end

   assign xa  = xa_ff;
   assign xab = xab_ff;

endmodule

`default_nettype wire

[rtl/factor_shape_accumulator_core.sv]
// Factor shape accumulator: three RAM stores updated by read-modify-write.
// Order: a word is accepted in idle, multiplied, and written back at commit, which waits
// for a free output register. One word is in flight at a time, since the read, multiply
// and write-back of one word pass through the single port pair of each RAM.
// Reset: synchronous; priors return to 1.0 and a clearing pass over
// max(ROWS*FACTORS, COLUMNS*FACTORS, FACTORS) entries zeroes the stores first.
`default_nettype none

module factor_shape_accumulator_core import fsa_pkg::*; #(
   parameter int ROWS    = 1024,
   parameter int FACTORS = 16,
   parameter int COLUMNS = 256
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_word_type      rsp_word,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_data
);

   localparam int RF_DEPTH = ROWS * FACTORS;
   localparam int CF_DEPTH = COLUMNS * FACTORS;
   localparam int FT_DEPTH = FACTORS;
   localparam int RF_AW    = (RF_DEPTH > 1) ? $clog2(RF_DEPTH) : 1;
   localparam int CF_AW    = (CF_DEPTH > 1) ? $clog2(CF_DEPTH) : 1;
   localparam int FT_AW    = (FT_DEPTH > 1) ? $clog2(FT_DEPTH) : 1;
   localparam int CLR_MAX  = (RF_DEPTH > CF_DEPTH) ? RF_DEPTH : CF_DEPTH;
   localparam int CLR_LEN  = (CLR_MAX > FT_DEPTH) ? CLR_MAX : FT_DEPTH;
   localparam int CLR_W    = (CLR_LEN > 1) ? $clog2(CLR_LEN) : 1;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_MUL   = 4'b0100,
      ST_WRITE = 4'b1000
   } state_type;

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
   endfunction

   state_type          state_ff, state_in;
   logic [CLR_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;
   logic [PRIOR_W-1:0] row_prior_ff, row_prior_in;
   logic [PRIOR_W-1:0] column_prior_ff, column_prior_in;
   logic [PRIOR_W-1:0] factor_prior_ff, factor_prior_in;
   req_word_type       item_ff;
   logic [RF_AW-1:0]   rf_addr_ff, rf_addr_in;
   logic [CF_AW-1:0]   cf_addr_ff, cf_addr_in;
   logic [FT_AW-1:0]   ft_addr_ff, ft_addr_in;
   logic               acc_ok_ff, acc_ok_in;
   logic               rd_ok_ff, rd_ok_in;

   logic               accept;
   logic               rsp_free;
   logic               commit;
   logic [31:0]        rf_flat, cf_flat, rd_flat, ft_flat, clr_flat;
   mul_ctl_type        mul_ctl;
   logic [XA_W-1:0]    xa;
   logic [XAB_W-1:0]   xab;

   logic               rf_we, cf_we, ft_we;
   logic [RF_AW-1:0]   rf_waddr;
   logic [CF_AW-1:0]   cf_waddr;
   logic [FT_AW-1:0]   ft_waddr;
   logic [SUM_W-1:0]   rf_wdata, cf_wdata, ft_wdata;
   logic [SUM_W-1:0]   rf_rdata, cf_rdata, ft_rdata;

   assign accept    = (state_ff == ST_IDLE) && req_valid;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == ST_WRITE) && rsp_free;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Flat entry indexes and range checks of the incoming word.
   always_comb begin
      rf_flat = 32'(req_word.factor_index) * 32'(ROWS) + 32'(req_word.row_index);
      cf_flat = 32'(req_word.col_index) * 32'(FACTORS) + 32'(req_word.factor_index);
      ft_flat = 32'(req_word.factor_index);
      rd_flat = 32'(req_word.read_index);
      acc_ok_in = (32'(req_word.row_index) < 32'(ROWS)) &&
                  (32'(req_word.factor_index) < 32'(FACTORS)) &&
                  (32'(req_word.col_index) < 32'(COLUMNS));
      unique case (req_word.which_store)
         SEL_ROW_FACTOR:    rd_ok_in = rd_flat < 32'(RF_DEPTH);
         SEL_COLUMN_FACTOR: rd_ok_in = rd_flat < 32'(CF_DEPTH);
         SEL_FACTOR_TOTAL:  rd_ok_in = rd_flat < 32'(FT_DEPTH);
         default:           rd_ok_in = 1'b0;
      endcase
      if (req_word.op == OP_READ) begin
         rf_addr_in = rd_flat[RF_AW-1:0];
         cf_addr_in = rd_flat[CF_AW-1:0];
         ft_addr_in = rd_flat[FT_AW-1:0];
      end else begin
         rf_addr_in = rf_flat[RF_AW-1:0];
         cf_addr_in = cf_flat[CF_AW-1:0];
         ft_addr_in = ft_flat[FT_AW-1:0];
      end
   end

   // The product unit loads x*pa on accept and the second product in the following cycle, in the multiply state.
   always_comb begin
      mul_ctl.load_xa  = accept;
      mul_ctl.load_xab = (state_ff == ST_MUL);
   end

   fsa_product u_product (
      .clock       (clock),
      .ctl         (mul_ctl),
      .count_value (req_word.count_value),
      .phi_a_value (req_word.phi_a_value),
      .phi_b_value (item_ff.phi_b_value),
      .xa          (xa),
      .xab         (xab)
   );

   // Write-back: clearing pass after reset, then sums or zeroes at commit.
   always_comb begin
      clr_flat    = 32'(clr_cnt_ff);
      rf_we       = 1'b0;
      cf_we       = 1'b0;
      ft_we       = 1'b0;
      rf_waddr    = rf_addr_ff;
      cf_waddr    = cf_addr_ff;
      ft_waddr    = ft_addr_ff;
      rf_wdata    = '0;
      cf_wdata    = '0;
      ft_wdata    = '0;
      rsp_word_in = '0;
      if (state_ff == ST_CLEAR) begin
         rf_we    = clr_flat < 32'(RF_DEPTH);
         cf_we    = clr_flat < 32'(CF_DEPTH);
         ft_we    = clr_flat < 32'(FT_DEPTH);
         rf_waddr = clr_flat[RF_AW-1:0];
         cf_waddr = clr_flat[CF_AW-1:0];
         ft_waddr = clr_flat[FT_AW-1:0];
      end else if (commit) begin
         if (item_ff.op == OP_ACCUMULATE) begin
            if (acc_ok_ff) begin
               rf_we    = 1'b1;
               cf_we    = 1'b1;
               ft_we    = 1'b1;
               rf_wdata = sat_add(rf_rdata, SUM_W'(xab));
               cf_wdata = sat_add(cf_rdata, SUM_W'(xa));
               ft_wdata = sat_add(ft_rdata, SUM_W'(xab));
            end
         end else begin
            rsp_word_in.is_read = 1'b1;
            if (rd_ok_ff) begin
               unique case (item_ff.which_store)
                  SEL_ROW_FACTOR: begin
                     rf_we = 1'b1;
                     rsp_word_in.read_value = sat_add(SUM_W'(row_prior_ff), rf_rdata);
                  end
                  SEL_COLUMN_FACTOR: begin
                     cf_we = 1'b1;
                     rsp_word_in.read_value = sat_add(SUM_W'(column_prior_ff), cf_rdata);
                  end
                  SEL_FACTOR_TOTAL: begin
                     ft_we = 1'b1;
                     rsp_word_in.read_value = sat_add(SUM_W'(factor_prior_ff), ft_rdata);
                  end
                  default: begin
                     rsp_word_in.read_value = '0;
                  end
               endcase
            end
         end
      end
   end

   fsa_ram #(.WIDTH(SUM_W), .DEPTH(RF_DEPTH)) u_row_factor_ram (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_en   (accept),
      .rd_addr (rf_addr_in),
      .rd_data (rf_rdata)
   );

   fsa_ram #(.WIDTH(SUM_W), .DEPTH(CF_DEPTH)) u_column_factor_ram (
      .clock   (clock),
      .wr_en   (cf_we),
      .wr_addr (cf_waddr),
      .wr_data (cf_wdata),
      .rd_en   (accept),
      .rd_addr (cf_addr_in),
      .rd_data (cf_rdata)
   );

   fsa_ram #(.WIDTH(SUM_W), .DEPTH(FT_DEPTH)) u_factor_total_ram (
      .clock   (clock),
      .wr_en   (ft_we),
      .wr_addr (ft_waddr),
      .wr_data (ft_wdata),
      .rd_en   (accept),
      .rd_addr (ft_addr_in),
      .rd_data (ft_rdata)
   );

   // Sequencer: clearing pass, then accept, multiply, write back and answer.
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + CLR_W'(1);
            if (clr_cnt_ff == CLR_W'(CLR_LEN - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The output register takes a new word whenever the sequencer commits.
   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Configuration writes; indexes beyond the list are dropped.
   always_comb begin
      row_prior_in    = row_prior_ff;
      column_prior_in = column_prior_ff;
      factor_prior_in = factor_prior_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ROW_PRIOR:    row_prior_in    = csr_data;
            CSR_COLUMN_PRIOR: column_prior_in = csr_data;
            CSR_FACTOR_PRIOR: factor_prior_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_cnt_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
         row_prior_ff    <= PRIOR_RESET;
         column_prior_ff <= PRIOR_RESET;
         factor_prior_ff <= PRIOR_RESET;
      end else begin
         state_ff        <= state_in;
         clr_cnt_ff      <= clr_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
         row_prior_ff    <= row_prior_in;
         column_prior_ff <= column_prior_in;
         factor_prior_ff <= factor_prior_in;
      end
   end

   // Payload registers of the word in flight and of the result word.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff    <= req_word;
         rf_addr_ff <= rf_addr_in;
         cf_addr_ff <= cf_addr_in;
         ft_addr_ff <= ft_addr_in;
         acc_ok_ff  <= acc_ok_in;
         rd_ok_ff   <= rd_ok_in;
      end
      if (commit) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

`default_nettype wire

[rtl/fsa_checker.sv]
// Port-level checker of the factor shape accumulator, bound to the top level.
// Depends on fsa_pkg and the assertion macros in factor_shape_accumulator_core_assert.svh.
`default_nettype none

`include "factor_shape_accumulator_core_assert.svh"

module fsa_checker import fsa_pkg::*; (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_ready,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire rsp_word_type rsp_word
);

   // A stalled result word must not change.
   `FSA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word), "result word changed while stalled")

   // An accumulate word never carries a value.
   `FSA_ASSERT_IMPLY(a_acc_zero, clock, reset, rsp_valid && !rsp_word.is_read, rsp_word.read_value == 64'd0, "accumulate word carries a value")

   // One word is in flight at a time, so ready drops after every accept.
   `FSA_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "input accepted twice in a row")

   // Reset empties the output and starts the clearing pass.
   `FSA_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid && !req_ready, "block not quiet after reset")

endmodule

bind factor_shape_accumulator_core fsa_checker u_fsa_checker (.*);

`default_nettype wire
